>>> src/dmsp_pkg.sv
`default_nettype none

package dmsp_pkg;

   // Depth of the result queue behind the parser; one byte can add two entries.
   localparam int QUEUE_DEPTH = 4;

   // Parser position within one angle.
   typedef enum logic [2:0] {
      P_START = 3'd0,
      P_DEG   = 3'd1,
      P_MIN   = 3'd2,
      P_SEC   = 3'd3,
      P_TAIL  = 3'd4,
      P_GAP   = 3'd5,
      P_DONE  = 3'd6
   } phase_type;

   // Sign letter seen for the current angle.
   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_MINUS = 2'd1,
      SIGN_PLUS  = 2'd2
   } sign_type;

   // Result status codes.
   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_DEG_RANGE = 4'd1,
      ST_DEG_DIGIT = 4'd2,
      ST_DEG_SEP   = 4'd3,
      ST_MIN_RANGE = 4'd4,
      ST_MIN_DIGIT = 4'd5,
      ST_MIN_SEP   = 4'd6,
      ST_SEC_RANGE = 4'd7,
      ST_SEC_DIGIT = 4'd8,
      ST_SIGN      = 4'd9
   } status_type;

   // One result item.
   typedef struct packed {
      logic       which_angle;
      logic       negative;
      logic [7:0] degrees;
      logic [5:0] minutes;
      logic [5:0] seconds;
      status_type status;
      logic       last_of_run;
   } rsp_type;

   // Character codes.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_W      = 8'h57;
   localparam logic [7:0] CH_E      = 8'h45;

   // Range limits.
   localparam logic [7:0] LAT_LIMIT = 8'd90;
   localparam logic [7:0] LON_LIMIT = 8'd180;
   localparam logic [7:0] MS_LIMIT  = 8'd60;

endpackage

`default_nettype wire

>>> src/dms_coordinate_text_parser_top.sv
// Coordinate text parser: reads a latitude and a longitude written in degrees,
// minutes and seconds, one text byte per beat.
// Input channel req_*: one byte per beat in req_tdata; byte 0 ends the string
// and returns the parser to the start of a latitude.
// Result channel rsp_*: one beat per completed angle or per first error.
// rsp_tuser says which angle, rsp_tlast marks the final result of one byte.
// A byte yields zero, one or two results; after an error or a finished
// longitude, bytes give nothing until byte 0 arrives.
// An accepted byte goes into the input register; the parse step then writes
// its results into the result queue, from which the receiver takes them.
// Throughput: one byte per cycle while two queue entries are free; a byte
// that gives two results needs two result beats.
// The four-entry result queue holds results while the receiver stalls;
// req_tready drops while the input register holds a byte and fewer than two
// entries are free.
// Reset (synchronous, active high) empties the queue and the input register
// and puts the parser at the start of a latitude with no sign seen.
`default_nettype none

module dms_coordinate_text_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: char_code[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // rsp_tdata: negative[0], degrees[8:1], minutes[14:9], seconds[20:15],
   // status[24:21], zero[31:25]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   // rsp_tuser: which_angle[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   localparam int QUEUE_DEPTH = dmsp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Input register.
   logic                  in_valid_ff;
   logic [7:0]            in_char_ff;

   // Parser state.
   dmsp_pkg::phase_type   phase_ff, phase_in;
   logic                  angle_ff, angle_in;
   dmsp_pkg::sign_type    sign_ff, sign_in;
   logic [7:0]            deg_ff, deg_in;
   logic [7:0]            min_ff, min_in;
   logic [7:0]            sec_ff, sec_in;
   logic                  seen_ff, seen_in;

   // Result queue.
   dmsp_pkg::rsp_type     q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // Parse step signals.
   logic                  room;
   logic                  fire;
   logic                  pop;
   logic [1:0]            push_n;
   logic                  ch_ws;
   logic                  ch_digit;
   logic [3:0]            ch_val;
   logic                  ch_minus;
   logic                  ch_plus;
   logic                  start_now;
   logic                  num_now;
   logic                  tail_now;
   logic                  second_now;
   logic                  fail_now;
   logic                  complete_now;
   logic                  tail_sign;
   dmsp_pkg::status_type  fail_code;
   dmsp_pkg::phase_type   num_k;
   logic                  num_seen;
   logic [7:0]            num_acc;
   logic [7:0]            num_limit;
   dmsp_pkg::status_type  num_rng;
   dmsp_pkg::status_type  num_dig;
   logic [7:0]            num_next;
   logic                  r0_valid;
   logic                  r1_valid;
   dmsp_pkg::rsp_type     r0;
   dmsp_pkg::rsp_type     r1;
   dmsp_pkg::rsp_type     head;

   // Decimal accumulate with saturation at 255.
   function automatic logic [7:0] acc_step(input logic [7:0] acc, input logic [3:0] d);
      logic [11:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, d};
      return (v > 12'd255) ? 8'hFF : v[7:0];
   endfunction

   // Handshakes: the parse step runs when two queue entries are free.
   assign room       = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   // Character classes.
   assign ch_ws    = (in_char_ff != dmsp_pkg::CH_NUL) && (in_char_ff <= dmsp_pkg::CH_SPACE);
   assign ch_digit = (in_char_ff >= dmsp_pkg::CH_ZERO) && (in_char_ff <= dmsp_pkg::CH_NINE);
   assign ch_val   = 4'(in_char_ff - dmsp_pkg::CH_ZERO);
   assign ch_minus = in_char_ff == (angle_ff ? dmsp_pkg::CH_W : dmsp_pkg::CH_S);
   assign ch_plus  = in_char_ff == (angle_ff ? dmsp_pkg::CH_E : dmsp_pkg::CH_N);

   // Number being read: minutes or seconds in their own phases, else degrees.
   assign num_k = ((phase_ff == dmsp_pkg::P_MIN) || (phase_ff == dmsp_pkg::P_SEC))
                  ? phase_ff : dmsp_pkg::P_DEG;

   // Accumulator, limit and error codes of the number being read.
   always_comb begin
      unique case (num_k)
         dmsp_pkg::P_MIN: begin
            num_acc   = min_ff;
            num_limit = dmsp_pkg::MS_LIMIT;
            num_rng   = dmsp_pkg::ST_MIN_RANGE;
            num_dig   = dmsp_pkg::ST_MIN_DIGIT;
         end
         dmsp_pkg::P_SEC: begin
            num_acc   = sec_ff;
            num_limit = dmsp_pkg::MS_LIMIT;
            num_rng   = dmsp_pkg::ST_SEC_RANGE;
            num_dig   = dmsp_pkg::ST_SEC_DIGIT;
         end
         default: begin
            num_acc   = deg_ff;
            num_limit = angle_ff ? dmsp_pkg::LON_LIMIT : dmsp_pkg::LAT_LIMIT;
            num_rng   = dmsp_pkg::ST_DEG_RANGE;
            num_dig   = dmsp_pkg::ST_DEG_DIGIT;
         end
      endcase
   end

   assign num_next = acc_step(num_acc, ch_val);

   // Parse step: next state and up to two results for the registered byte.
   always_comb begin
      phase_in     = phase_ff;
      angle_in     = angle_ff;
      sign_in      = sign_ff;
      deg_in       = deg_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      seen_in      = seen_ff;
      start_now    = (phase_ff == dmsp_pkg::P_START)
                     || ((phase_ff == dmsp_pkg::P_GAP) && !ch_ws);
      num_now      = 1'b0;
      num_seen     = seen_ff;
      tail_now     = 1'b0;
      tail_sign    = 1'b0;
      second_now   = 1'b0;
      fail_now     = 1'b0;
      fail_code    = dmsp_pkg::ST_OK;
      complete_now = 1'b0;
      r0_valid     = 1'b0;
      r1_valid     = 1'b0;

      // Start of an angle: a leading sign letter, else straight into degrees.
      if (start_now) begin
         phase_in = dmsp_pkg::P_DEG;
         seen_in  = 1'b0;
         if (ch_minus) begin
            sign_in = dmsp_pkg::SIGN_MINUS;
         end else if (ch_plus) begin
            sign_in = dmsp_pkg::SIGN_PLUS;
         end else begin
            num_now  = 1'b1;
            num_seen = 1'b0;
         end
      end else if ((phase_ff == dmsp_pkg::P_DEG) || (phase_ff == dmsp_pkg::P_MIN)
                   || (phase_ff == dmsp_pkg::P_SEC)) begin
         num_now = 1'b1;
      end else if (phase_ff == dmsp_pkg::P_TAIL) begin
         tail_now = 1'b1;
      end

      // Number field: skip blanks, gather digits, then check what ended it.
      if (num_now) begin
         if (!num_seen && ch_ws) begin
            phase_in = num_k;
         end else if (ch_digit) begin
            seen_in = 1'b1;
            unique case (num_k)
               dmsp_pkg::P_MIN: min_in = num_next;
               dmsp_pkg::P_SEC: sec_in = num_next;
               default:         deg_in = num_next;
            endcase
         end else if (num_acc > num_limit) begin
            fail_now  = 1'b1;
            fail_code = num_rng;
         end else if (!num_seen) begin
            fail_now  = 1'b1;
            fail_code = num_dig;
         end else begin
            seen_in = 1'b0;
            unique case (num_k)
               dmsp_pkg::P_DEG: begin
                  if ((in_char_ff == dmsp_pkg::CH_SPACE) || (in_char_ff == dmsp_pkg::CH_DOT)) begin
                     phase_in = dmsp_pkg::P_MIN;
                  end else begin
                     fail_now  = 1'b1;
                     fail_code = dmsp_pkg::ST_DEG_SEP;
                  end
               end
               dmsp_pkg::P_MIN: begin
                  if ((in_char_ff == dmsp_pkg::CH_SPACE) || (in_char_ff == dmsp_pkg::CH_DOT)
                      || (in_char_ff == dmsp_pkg::CH_QUOTE)) begin
                     phase_in = dmsp_pkg::P_SEC;
                  end else begin
                     fail_now  = 1'b1;
                     fail_code = dmsp_pkg::ST_MIN_SEP;
                  end
               end
               default: begin
                  if (sign_ff != dmsp_pkg::SIGN_NONE) begin
                     // Leading sign given: the angle is complete now, and the
                     // same byte may already start the longitude.
                     complete_now = 1'b1;
                     second_now   = !angle_ff && (in_char_ff != dmsp_pkg::CH_DQUOTE) && !ch_ws;
                  end else begin
                     phase_in = dmsp_pkg::P_TAIL;
                     tail_now = in_char_ff != dmsp_pkg::CH_DQUOTE;
                  end
               end
            endcase
         end
      end

      // Trailing sign letter.
      if (tail_now) begin
         if (ch_ws) begin
            phase_in = dmsp_pkg::P_TAIL;
         end else if (ch_minus || ch_plus) begin
            tail_sign    = 1'b1;
            complete_now = 1'b1;
         end else begin
            fail_now  = 1'b1;
            fail_code = dmsp_pkg::ST_SIGN;
         end
      end

      // First result: an error or a completed angle.
      r0.which_angle = angle_ff;
      r0.negative    = 1'b0;
      r0.degrees     = 8'd0;
      r0.minutes     = 6'd0;
      r0.seconds     = 6'd0;
      r0.status      = fail_code;
      r0.last_of_run = 1'b1;
      if (fail_now) begin
         r0_valid = 1'b1;
         phase_in = dmsp_pkg::P_DONE;
      end
      if (complete_now) begin
         r0_valid    = 1'b1;
         r0.negative = tail_sign ? ch_minus : (sign_ff == dmsp_pkg::SIGN_MINUS);
         r0.degrees  = deg_ff;
         r0.minutes  = min_ff[5:0];
         r0.seconds  = sec_ff[5:0];
         r0.status   = dmsp_pkg::ST_OK;
         if (!angle_ff) begin
            angle_in = 1'b1;
            sign_in  = dmsp_pkg::SIGN_NONE;
            deg_in   = 8'd0;
            min_in   = 8'd0;
            sec_in   = 8'd0;
            seen_in  = 1'b0;
            phase_in = dmsp_pkg::P_GAP;
         end else begin
            phase_in = dmsp_pkg::P_DONE;
         end
      end

      // Second result: the byte that ended the latitude seconds cannot begin
      // the longitude unless it is a longitude sign letter.
      r1.which_angle = 1'b1;
      r1.negative    = 1'b0;
      r1.degrees     = 8'd0;
      r1.minutes     = 6'd0;
      r1.seconds     = 6'd0;
      r1.status      = dmsp_pkg::ST_DEG_DIGIT;
      r1.last_of_run = 1'b1;
      if (second_now) begin
         if (in_char_ff == dmsp_pkg::CH_W) begin
            sign_in  = dmsp_pkg::SIGN_MINUS;
            phase_in = dmsp_pkg::P_DEG;
         end else if (in_char_ff == dmsp_pkg::CH_E) begin
            sign_in  = dmsp_pkg::SIGN_PLUS;
            phase_in = dmsp_pkg::P_DEG;
         end else begin
            r1_valid = 1'b1;
            phase_in = dmsp_pkg::P_DONE;
         end
      end
      r0.last_of_run = !r1_valid;

      // End of string: back to the start of a latitude.
      if (in_char_ff == dmsp_pkg::CH_NUL) begin
         phase_in = dmsp_pkg::P_START;
         angle_in = 1'b0;
         sign_in  = dmsp_pkg::SIGN_NONE;
         deg_in   = 8'd0;
         min_in   = 8'd0;
         sec_in   = 8'd0;
         seen_in  = 1'b0;
      end
   end

   // Parser state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dmsp_pkg::P_START;
         angle_ff <= 1'b0;
         sign_ff  <= dmsp_pkg::SIGN_NONE;
         deg_ff   <= 8'd0;
         min_ff   <= 8'd0;
         sec_ff   <= 8'd0;
         seen_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         angle_ff <= angle_in;
         sign_ff  <= sign_in;
         deg_ff   <= deg_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         seen_ff  <= seen_in;
      end
   end

   // Result queue pointers and fill count.
   assign push_n    = fire ? ({1'b0, r0_valid} + {1'b0, r1_valid}) : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the second result goes in behind the first.
   always_ff @(posedge clock) begin
      if (fire && r0_valid) begin
         q_ff[wr_ptr_ff] <= r0;
      end
      if (fire && r1_valid) begin
         q_ff[wr_ptr_ff + PTR_W'(1)] <= r1;
      end
   end

   // Result beat from the queue head.
   assign head      = q_ff[rd_ptr_ff];
   assign rsp_tdata = {7'd0, head.status, head.seconds, head.minutes, head.degrees,
                       head.negative};
   assign rsp_tuser = head.which_angle;
   assign rsp_tlast = head.last_of_run;

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   // A parse step never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fire |-> ({1'b0, count_ff} + (CNT_W + 1)'(push_n)) <= (CNT_W + 1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // Two results from one byte: a finished latitude, then a longitude error.
   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (fire && r1_valid) |-> (r0_valid && !angle_ff && (r0.status == dmsp_pkg::ST_OK)
                              && !r0.last_of_run))
      else $error("unexpected result pair");

   // Byte 0 returns the parser to the start of a latitude.
   a_nul_resets: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_char_ff == dmsp_pkg::CH_NUL))
      |=> ((phase_ff == dmsp_pkg::P_START) && !angle_ff))
      else $error("byte 0 did not reset the parser");

   // Once done, the parser stays done until byte 0.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == dmsp_pkg::P_DONE) && !(fire && (in_char_ff == dmsp_pkg::CH_NUL)))
      |=> (phase_ff == dmsp_pkg::P_DONE))
      else $error("parser left the done phase");

endmodule

`default_nettype wire
